// File: rtl/zfc_pkg.sv
// Zero-forcing closure: shared types and constants.
// Used by zfc_cell and zero_forcing_closure; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package zfc_pkg;

    localparam int unsigned SET_W   = 8;
    localparam int unsigned ROUND_W = 4;
    localparam int unsigned ADJ_W   = 64;
    localparam int unsigned COUNT_W = 4;

    // Configuration register indexes
    localparam logic REG_ADJACENCY = 1'b0;
    localparam logic REG_COUNT     = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

    // One transaction as it moves down the row of cells
    typedef struct packed {
        logic               valid;
        logic [SET_W-1:0]   set;
        logic [ROUND_W-1:0] rounds;
    } stage_t;

    // Exactly one bit set
    function automatic logic single_bit(input logic [SET_W-1:0] x);
        logic [SET_W-1:0] low;
        begin
            low = x - 8'd1;
            single_bit = (x != '0) && ((x & low) == '0);
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/zfc_cell.sv
// Zero-forcing closure: one cell of the chain, one forcing round per cell.
// Depends on zfc_pkg for the stage type and single_bit().
`timescale 1ns / 1ps
`default_nettype none

module zfc_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [zfc_pkg::ADJ_W-1:0] adjacency,
    input  wire logic [zfc_pkg::SET_W-1:0] vmask,
    input  wire zfc_pkg::stage_t           stage_in,
    output zfc_pkg::stage_t                stage_out
);

    zfc_pkg::stage_t stage_reg;
    zfc_pkg::stage_t stage_next;
    logic [zfc_pkg::SET_W-1:0] added;

    // Every force judged against the set at the start of the round
    always_comb
    begin
        logic [zfc_pkg::SET_W-1:0] row;
        logic [zfc_pkg::SET_W-1:0] outside;
        added = '0;
        for (int v = 0; v < zfc_pkg::SET_W; v++)
        begin
            row = adjacency[zfc_pkg::SET_W*v +: zfc_pkg::SET_W] & vmask;
            row[v] = 1'b0;
            outside = row & ~stage_in.set;
            if (stage_in.set[v] && zfc_pkg::single_bit(outside))
            begin
                added = added | outside;
            end
        end
    end

    always_comb
    begin
        stage_next.valid  = stage_in.valid;
        stage_next.set    = stage_in.set | added;
        stage_next.rounds = stage_in.rounds +
                            {{(zfc_pkg::ROUND_W-1){1'b0}}, (added != '0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

`default_nettype wire

// File: rtl/zero_forcing_closure.sv
// Zero-forcing closure top level: configuration registers, input stage and
// a row of MAX_VERTICES zfc_cell instances. Depends on zfc_pkg and zfc_cell.
//
// Usage:
//   Configure with wr_en / wr_index / wr_data: index 0 is the 64-bit
//   adjacency matrix (row i in bits 8*i+7..8*i), index 1 the vertex count.
//   Write only while no transaction is in flight.
//   A transaction is accepted when start is high and busy is low; busy is
//   never raised, so one initial_set may enter every cycle.
//   The input stage masks the set to the vertices in use; each cell then
//   applies one synchronous forcing round and hands its set on. Rounds that
//   add nothing leave the set unchanged, so the last cell holds the fixed
//   point.
//   A result passes through the input register and then one register per
//   cell of the row on its way to done; throughput is one transaction per cycle.
//   done is high for one cycle with closed_set, is_forcing and round_count;
//   the receiver cannot stall and must take the result then.
//   Reset clears the pipeline valid bits, the adjacency matrix to zero and
//   the vertex count to 8.
`timescale 1ns / 1ps
`default_nettype none

module zero_forcing_closure #(
    parameter int unsigned MAX_VERTICES = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic                          wr_index,
    input  wire logic [zfc_pkg::ADJ_W-1:0]     wr_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [zfc_pkg::SET_W-1:0]     initial_set,
    output logic                               done,
    output logic [zfc_pkg::SET_W-1:0]          closed_set,
    output logic                               is_forcing,
    output logic [zfc_pkg::ROUND_W-1:0]        round_count
);

    logic [zfc_pkg::ADJ_W-1:0]   adj_reg;
    logic [zfc_pkg::COUNT_W-1:0] count_reg;
    logic [zfc_pkg::COUNT_W-1:0] eff_count;
    logic [zfc_pkg::SET_W-1:0]   vmask;
    logic                        accept;

    zfc_pkg::stage_t in_reg;
    zfc_pkg::stage_t in_next;
    zfc_pkg::stage_t chain [MAX_VERTICES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_reg   <= '0;
            count_reg <= zfc_pkg::COUNT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                zfc_pkg::REG_ADJACENCY: adj_reg   <= wr_data;
                zfc_pkg::REG_COUNT:     count_reg <= wr_data[zfc_pkg::COUNT_W-1:0];
                default:                adj_reg   <= adj_reg;
            endcase
        end
    end

    // Clamp the count, then build the mask of vertices in use
    always_comb
    begin
        logic [zfc_pkg::SET_W:0] wide;
        if (count_reg > zfc_pkg::COUNT_W'(MAX_VERTICES))
        begin
            eff_count = zfc_pkg::COUNT_W'(MAX_VERTICES);
        end
        else
        begin
            eff_count = count_reg;
        end
        wide  = ((zfc_pkg::SET_W+1)'(1) << eff_count) - (zfc_pkg::SET_W+1)'(1);
        vmask = wide[zfc_pkg::SET_W-1:0];
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        in_next.valid  = accept;
        in_next.set    = initial_set & vmask;
        in_next.rounds = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
        end
        else
        begin
            in_reg <= in_next;
        end
    end

    assign chain[0] = in_reg;

    for (genvar c = 0; c < MAX_VERTICES; c++)
    begin : g_cell
        zfc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adjacency (adj_reg),
            .vmask     (vmask),
            .stage_in  (chain[c]),
            .stage_out (chain[c+1])
        );
    end

    assign done        = chain[MAX_VERTICES].valid;
    assign closed_set  = chain[MAX_VERTICES].set;
    assign round_count = chain[MAX_VERTICES].rounds;
    assign is_forcing  = (chain[MAX_VERTICES].set == vmask);

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, MAX_VERTICES + 1))
        else $error("result without a transaction accepted at the expected cycle");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((closed_set & ~vmask) == '0))
        else $error("closure holds a vertex outside the graph");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (round_count <= zfc_pkg::ROUND_W'(MAX_VERTICES)))
        else $error("round count exceeds the number of cells");

    a_grows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((closed_set & $past(initial_set & vmask, MAX_VERTICES + 1))
                  == $past(initial_set & vmask, MAX_VERTICES + 1)))
        else $error("closure lost a vertex of the initial set");
`endif

endmodule

`default_nettype wire
